### sv/pfbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbs_pkg
// Shared types, constants and the color palette of the BMP frame serializer.
// ----------------------------------------------------------------------------
package pfbs_pkg;

    localparam int CFG_W        = 9;
    localparam int HDR_BYTES    = 54;
    localparam int INFO_BYTES   = 40;
    localparam int BITS_PER_PIX = 24;
    localparam int PALETTE_SIZE = 14;

    localparam logic [15:0]      BMP_MAGIC   = 16'h4D42;
    localparam logic [CFG_W-1:0] RESET_DIM   = 9'd64;
    localparam logic [23:0]      WHITE_PIXEL = 24'hFFFFFF;

    typedef enum logic [1:0] {
        CMD_PAINT  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_REWIND = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_cmd       cmd;
        logic [3:0] color_index;
        logic [7:0] pixel_row;
        logic [7:0] pixel_col;
    } t_in_item;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       last_of_file;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic paint;
        logic rd_step;
        logic rewind;
        logic clr_step;
        logic div_start;
        logic seek_ro;
        logic seek_base;
        logic out_load;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic out_free;
    } t_dp_stat;

    // pixel word: red 23:16, green 15:8, blue 7:0
    function automatic logic [23:0] palette_color(input logic [3:0] idx);
        logic [23:0] c;
        unique case (idx)
            4'd0:    c = 24'hFF0000;
            4'd1:    c = 24'hFF790B;
            4'd2:    c = 24'hFFEF14;
            4'd3:    c = 24'h00FF00;
            4'd4:    c = 24'h029502;
            4'd5:    c = 24'h00FFFF;
            4'd6:    c = 24'hB80000;
            4'd7:    c = 24'hAA5500;
            4'd8:    c = 24'hE6C757;
            4'd9:    c = 24'hE942FF;
            4'd10:   c = 24'h000000;
            4'd11:   c = 24'h515151;
            4'd12:   c = 24'h9F9F9F;
            default: c = WHITE_PIXEL;
        endcase
        return c;
    endfunction

endpackage

### sv/pfbs_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbs_chan_if
// Valid/ready channel carrying one payload word per transaction.
// ----------------------------------------------------------------------------
interface pfbs_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/pfbs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pfbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/pfbs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfbs_div #(
    parameter int DW = 18,
    parameter int VW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot,
    output logic [VW-1:0] o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;

    logic [VW:0]   shifted;
    logic          take;

    always_comb begin
        shifted = {r_rem, r_quo[DW-1]};
        take    = shifted >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], take};
            r_rem <= take ? VW'(shifted - {1'b0, r_dvs}) : shifted[VW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

### sv/pfbs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbs_ctrl
// Sequencer: clearing sweep, geometry settle and read-position seek,
// command decode and read result handoff.
// ----------------------------------------------------------------------------
module pfbs_ctrl
    import pfbs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_item_valid,
    input  t_cmd     i_item_cmd,
    output logic     o_item_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETTLE,
        S_SEEK_RO,
        S_BASE,
        S_READ_OUT
    } t_state;

    // start value of the settle countdown that lets the geometry registers update after a config write
    localparam logic [1:0] SETTLE_INIT = 2'd2;

    t_state     r_state, n_state;
    logic       r_dirty, n_dirty;
    logic [1:0] r_settle, n_settle;
    logic       ready;
    logic       accept;

    assign ready  = (r_state == S_IDLE) && !r_dirty;
    assign accept = ready && i_item_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.paint     = accept && (i_item_cmd == CMD_PAINT);
        o_cmd.rd_step   = accept && (i_item_cmd == CMD_READ);
        o_cmd.rewind    = accept && (i_item_cmd == CMD_REWIND);
        o_cmd.clr_step  = r_state == S_CLEAR;
        o_cmd.div_start = (r_state == S_SETTLE) && (r_settle == 2'd0);
        o_cmd.seek_ro   = (r_state == S_SEEK_RO) && i_stat.div_done;
        o_cmd.seek_base = r_state == S_BASE;
        o_cmd.out_load  = (r_state == S_READ_OUT) && i_stat.out_free;
    end

    always_comb begin
        n_state  = r_state;
        n_dirty  = r_dirty;
        n_settle = r_settle;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (r_dirty) begin
                    n_state  = S_SETTLE;
                    n_dirty  = 1'b0;
                    n_settle = SETTLE_INIT;
                end else if (accept) begin
                    priority case (i_item_cmd)
                        CMD_READ:  n_state = S_READ_OUT;
                        CMD_CLEAR: n_state = S_CLEAR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_SETTLE: begin
                if (r_settle == 2'd0) begin
                    n_state = S_SEEK_RO;
                end else begin
                    n_settle = r_settle - 2'd1;
                end
            end
            S_SEEK_RO: begin
                if (i_stat.div_done) begin
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                n_state = S_IDLE;
            end
            S_READ_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // a new write always forces another settle and seek
        if (i_cfg_we) begin
            n_dirty = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_dirty  <= 1'b1;
            r_settle <= SETTLE_INIT;
        end else begin
            r_state  <= n_state;
            r_dirty  <= n_dirty;
            r_settle <= n_settle;
        end
    end

    assign o_item_ready = ready;

endmodule

### sv/pfbs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbs_dp
// Datapath: configuration and derived geometry, frame store, read-position
// counters, header generation, seek divider and output register.
// ----------------------------------------------------------------------------
module pfbs_dp
    import pfbs_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_in_item             i_item,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    pfbs_chan_if.source          o_result
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WV     = $clog2(MAX_WIDTH + 1);
    localparam int HV     = $clog2(MAX_HEIGHT + 1);
    localparam int OW     = $clog2(3 * MAX_WIDTH + 4);
    localparam int PW     = $clog2(HDR_BYTES + (3 * MAX_WIDTH + 3) * MAX_HEIGHT + 1);
    localparam int XW     = OW + 17;
    localparam int RECIP3 = 43691;

    // ---------------- configuration and geometry ----------------
    logic [CFG_W-1:0] r_cfg_w, r_cfg_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RESET_DIM;
            r_cfg_h <= RESET_DIM;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data;
                default:          r_cfg_w <= r_cfg_w;
            endcase
        end
    end

    logic [WV-1:0] n_w, r_w;
    logic [HV-1:0] n_h, r_h;
    logic [OW-1:0] n_w3, r_w3;
    logic [OW-1:0] n_row_bytes, r_row_bytes;
    logic [PW-1:0] r_img, r_total;
    logic [AW-1:0] r_last_base;
    logic [HV-1:0] h_m1;

    // zero is taken as one, anything above the maximum as the maximum
    always_comb begin
        if (r_cfg_w == '0) begin
            n_w = WV'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            n_w = WV'(MAX_WIDTH);
        end else begin
            n_w = WV'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            n_h = HV'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            n_h = HV'(MAX_HEIGHT);
        end else begin
            n_h = HV'(r_cfg_h);
        end
        n_w3        = OW'(n_w) + OW'(n_w) + OW'(n_w);
        n_row_bytes = (n_w3 + OW'(3)) & ~OW'(3);
        h_m1        = r_h - HV'(1);
    end

    always_ff @(posedge i_clk) begin
        r_w         <= n_w;
        r_h         <= n_h;
        r_w3        <= n_w3;
        r_row_bytes <= n_row_bytes;
        r_img       <= PW'(r_row_bytes) * PW'(r_h);
        r_last_base <= AW'(h_m1) * AW'(r_w);
        r_total     <= r_img + PW'(HDR_BYTES);
    end

    // ---------------- frame store ----------------
    logic [AW-1:0] r_clr;
    logic [AW-1:0] paint_addr;
    logic          paint_ok;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [23:0]   ram_wdata;
    logic [AW-1:0] rd_addr;
    logic [23:0]   ram_rdata;

    always_comb begin
        paint_addr = AW'(i_item.pixel_row) * AW'(r_w) + AW'(i_item.pixel_col);
        paint_ok   = (i_item.color_index < 4'(PALETTE_SIZE))
                     && (32'(i_item.pixel_row) < 32'(r_h))
                     && (32'(i_item.pixel_col) < 32'(r_w));
        if (i_cmd.clr_step) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = WHITE_PIXEL;
        end else begin
            ram_we    = i_cmd.paint && paint_ok;
            ram_waddr = paint_addr;
            ram_wdata = palette_color(i_item.color_index);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= (r_clr == AW'(DEPTH - 1)) ? '0 : r_clr + AW'(1);
        end
    end

    pfbs_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_step),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // ---------------- read position ----------------
    logic [PW-1:0] r_pos;
    logic [HV-1:0] r_row;   // rows counted from the bottom of the image
    logic [OW-1:0] r_off;   // byte within the row
    logic [WV-1:0] r_x;
    logic [1:0]    r_comp;
    logic [AW-1:0] r_base;

    logic [PW-1:0] p_eff;
    logic          is_hdr, is_pad, is_last, row_end;
    logic [431:0]  hdr_vec;
    logic [7:0]    hdr_byte;
    logic [HV-1:0] seek_y;

    logic          div_done;
    logic [PW-1:0] div_quot;
    logic [OW-1:0] div_rem;
    logic [XW-1:0] xc_prod;
    logic [OW-1:0] xc_quot;
    logic [OW-1:0] xc_rem;

    always_comb begin
        p_eff   = (r_pos >= r_total) ? '0 : r_pos;
        is_hdr  = p_eff < PW'(HDR_BYTES);
        is_pad  = r_off >= r_w3;
        is_last = p_eff == r_total - PW'(1);
        row_end = r_off == r_row_bytes - OW'(1);
        rd_addr = r_base + AW'(r_x);
        seek_y  = h_m1 - r_row;
        hdr_vec = {128'd0, 32'(r_img), 32'd0, 16'(BITS_PER_PIX), 16'd1,
                   32'(r_h), 32'(r_w), 32'(INFO_BYTES), 32'(HDR_BYTES),
                   32'd0, 32'(r_total), BMP_MAGIC};
        hdr_byte = hdr_vec[{p_eff[5:0], 3'b000} +: 8];
        // split the row offset into pixel and color byte: multiply by 2^17/3,
        // exact for offsets below 2^17
        xc_prod = XW'(div_rem) * XW'(RECIP3);
        xc_quot = OW'(xc_prod >> 17);
        xc_rem  = div_rem - (xc_quot + xc_quot + xc_quot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_row  <= '0;
            r_off  <= '0;
            r_x    <= '0;
            r_comp <= '0;
            r_base <= '0;
        end else if (i_cmd.rd_step) begin
            r_pos <= is_last ? '0 : p_eff + PW'(1);
            if (is_hdr) begin
                // header bytes park the pixel walk at the bottom-left corner
                r_row  <= '0;
                r_off  <= '0;
                r_x    <= '0;
                r_comp <= '0;
                r_base <= r_last_base;
            end else if (row_end) begin
                r_row  <= r_row + HV'(1);
                r_off  <= '0;
                r_x    <= '0;
                r_comp <= '0;
                r_base <= r_base - AW'(r_w);
            end else begin
                r_off <= r_off + OW'(1);
                if (!is_pad) begin
                    if (r_comp == 2'd2) begin
                        r_comp <= '0;
                        r_x    <= r_x + WV'(1);
                    end else begin
                        r_comp <= r_comp + 2'd1;
                    end
                end
            end
        end else if (i_cmd.rewind) begin
            r_pos <= '0;
        end else if (i_cmd.seek_ro) begin
            r_row  <= HV'(div_quot);
            r_off  <= div_rem;
            r_x    <= WV'(xc_quot);
            r_comp <= 2'(xc_rem);
        end else if (i_cmd.seek_base) begin
            r_base <= AW'(seek_y) * AW'(r_w);
        end
    end

    // seek: row and offset from the pixel byte index
    pfbs_div #(
        .DW (PW),
        .VW (OW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_pos - PW'(HDR_BYTES)),
        .i_divisor  (r_row_bytes),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // ---------------- result ----------------
    logic       r_sel_hdr, r_sel_pad, r_last_pend;
    logic [1:0] r_csel;
    logic [7:0] r_hdr_byte;
    logic [7:0] pix_byte;
    logic [7:0] res_byte;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_step) begin
            r_sel_hdr   <= is_hdr;
            r_sel_pad   <= is_pad;
            r_csel      <= r_comp;
            r_hdr_byte  <= hdr_byte;
            r_last_pend <= is_last;
        end
    end

    always_comb begin
        unique case (r_csel)
            2'd0:    pix_byte = ram_rdata[7:0];
            2'd1:    pix_byte = ram_rdata[15:8];
            2'd2:    pix_byte = ram_rdata[23:16];
            default: pix_byte = 8'd0;
        endcase
        if (r_sel_hdr) begin
            res_byte = r_hdr_byte;
        end else if (r_sel_pad) begin
            res_byte = 8'd0;
        end else begin
            res_byte = pix_byte;
        end
    end

    logic      r_out_valid;
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.file_byte    <= res_byte;
            r_out.last_of_file <= r_last_pend;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    assign o_stat.clr_last = r_clr == AW'(DEPTH - 1);
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_out_valid || o_result.ready;

endmodule

### sv/palette_framebuffer_bmp_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_framebuffer_bmp_serializer
// Palette-painted 24-bit frame store streamed out as a BMP file, byte by byte.
//
//  Port        Dir   Payload                                   Transfer
//  i_item      in    cmd, color_index, pixel_row, pixel_col    valid & ready
//  o_result    out   file_byte, last_of_file                   valid & ready
//  i_cfg_*     in    index 0 image_width, 1 image_height       i_cfg_we
//
//  Paint and rewind take effect when accepted; a read goes through the
//  frame store access, then the output register, and waits before the
//  output register only while o_result stalls. Clear sweeps all
//  MAX_WIDTH*MAX_HEIGHT frame store entries, one entry per cycle; reset
//  starts with the same sweep. After reset or a config write, a settle
//  and a seek through the PW-bit divider (PW = position width, 18 by
//  default) follow; no item is accepted until they complete.
// ----------------------------------------------------------------------------
module palette_framebuffer_bmp_serializer
    import pfbs_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    pfbs_chan_if.sink        i_item,
    pfbs_chan_if.source      o_result
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    t_in_item item;

    assign item = i_item.data;

    pfbs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_item_valid (i_item.valid),
        .i_item_cmd   (item.cmd),
        .o_item_ready (i_item.ready),
        .i_stat       (dp_stat),
        .o_cmd        (dp_cmd)
    );

    pfbs_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (item),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_result    (o_result)
    );

endmodule
